// ===== hdl/cdq_pkg.sv =====
// Package with shared types and codes for the circular deque.
package cdq_pkg;

  localparam int CAP_W  = 5;
  localparam int WORD_W = 32;

  localparam logic [2:0] FUNC_INS_FRONT = 3'd0;
  localparam logic [2:0] FUNC_INS_REAR  = 3'd1;
  localparam logic [2:0] FUNC_DEL_FRONT = 3'd2;
  localparam logic [2:0] FUNC_DEL_REAR  = 3'd3;
  localparam logic [2:0] FUNC_PEEK      = 3'd4;

  typedef struct packed {
    logic [2:0]               func;
    logic signed [WORD_W-1:0] value;
  } cdq_in_t;

  typedef struct packed {
    logic                     ok;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;
    logic [CAP_W-1:0]         count;
  } cdq_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_DONE
  } cdq_state_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic read;
    logic load_out;
  } cdq_cmd_t;

  typedef struct packed {
    logic out_free;
  } cdq_sts_t;

endpackage

// ===== hdl/circular_deque_top.sv =====
// Top level of the circular deque: controller plus datapath.
//
//   channel  direction  handshake             word
//   in_      input      in_valid / in_ready   cdq_in_t  (func, value)
//   out_     output     out_valid / out_ready cdq_out_t (ok, front/rear, flags, count)
//   cfg_     input      cfg_we (no wait)      capacity, 5 bits
//
// An item passes the controller steps in order: accept, pointer update and
// storage write, registered storage read, load of the output register.
// The output register lets the next word enter while a result waits;
// a stalled output holds the controller in its last step.
// Reset and capacity writes empty the deque at once; no clearing pass.
module circular_deque_top #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  cdq_pkg::cdq_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output cdq_pkg::cdq_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [cdq_pkg::CAP_W-1:0] cfg_wdata
);
  import cdq_pkg::*;

  cdq_cmd_t cmd;
  cdq_sts_t sts;

  cdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cdq_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/cdq_ctrl.sv =====
// Controller state machine that steps one word through the datapath.
module cdq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cdq_pkg::cdq_sts_t sts,
  output cdq_pkg::cdq_cmd_t cmd
);
  import cdq_pkg::*;

  cdq_state_t st_r;
  cdq_state_t st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    cmd      = '0;
    in_ready = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          st_nxt      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        st_nxt   = ST_READ;
      end
      ST_READ: begin
        cmd.read = 1'b1;
        st_nxt   = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register can take the word
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          st_nxt       = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/cdq_dpath.sv =====
// Datapath: pointers, fill count, capacity, storage and output register.
module cdq_dpath #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cdq_pkg::cdq_in_t            in_data,
  input  logic                        cfg_we,
  input  logic [cdq_pkg::CAP_W-1:0]   cfg_wdata,
  input  cdq_pkg::cdq_cmd_t           cmd,
  output cdq_pkg::cdq_sts_t           sts,
  output logic                        out_valid,
  input  logic                        out_ready,
  output cdq_pkg::cdq_out_t           out_data
);
  import cdq_pkg::*;

  // capacity never exceeds the register range, so deeper storage is unused
  localparam int CAP_MAX   = (1 << CAP_W) - 1;
  localparam int MEM_DEPTH = (DEPTH < CAP_MAX) ? DEPTH : CAP_MAX;
  localparam int PTR_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int RST_CAP   = (MEM_DEPTH < 16) ? MEM_DEPTH : 16;

  logic signed [DATA_WIDTH-1:0] mem [MEM_DEPTH];

  cdq_in_t                      in_r;
  logic [PTR_W-1:0]             head_r, head_nxt;
  logic [PTR_W-1:0]             tail_r, tail_nxt;
  logic [CAP_W-1:0]             fill_r, fill_nxt;
  logic [CAP_W-1:0]             cap_r, cap_nxt;
  logic                         ok_r, ok_nxt;
  logic signed [DATA_WIDTH-1:0] rd_head_r, rd_tail_r;
  logic                         out_valid_r, out_valid_nxt;
  cdq_out_t                     out_data_r;

  logic                         wr_en;
  logic [PTR_W-1:0]             wr_addr;
  logic signed [DATA_WIDTH-1:0] wr_data;
  logic [CAP_W-1:0]             cap_eff;
  logic [PTR_W-1:0]             cap_m1;
  logic [PTR_W-1:0]             head_inc, head_dec, tail_inc, tail_dec;
  logic                         has_room, has_data;

  assign wr_data  = DATA_WIDTH'(in_r.value);
  assign cap_m1   = PTR_W'(cap_r - CAP_W'(1));
  assign head_inc = (CAP_W'(head_r) + CAP_W'(1) >= cap_r) ? '0 : head_r + PTR_W'(1);
  assign tail_inc = (CAP_W'(tail_r) + CAP_W'(1) >= cap_r) ? '0 : tail_r + PTR_W'(1);
  assign head_dec = (head_r == '0) ? cap_m1 : head_r - PTR_W'(1);
  assign tail_dec = (tail_r == '0) ? cap_m1 : tail_r - PTR_W'(1);
  assign has_room = (fill_r < cap_r);
  assign has_data = (fill_r != '0);

  // clamp a written capacity into 1..MEM_DEPTH
  always_comb begin
    if (cfg_wdata == '0) begin
      cap_eff = CAP_W'(1);
    end else if (int'(cfg_wdata) > MEM_DEPTH) begin
      cap_eff = CAP_W'(MEM_DEPTH);
    end else begin
      cap_eff = cfg_wdata;
    end
  end

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    cap_nxt  = cap_r;
    ok_nxt   = ok_r;
    wr_en    = 1'b0;
    wr_addr  = head_dec;
    if (cmd.exec) begin
      ok_nxt = 1'b0;
      unique case (in_r.func)
        FUNC_INS_FRONT: begin
          if (has_room) begin
            head_nxt = head_dec;
            wr_en    = 1'b1;
            wr_addr  = head_dec;
            fill_nxt = fill_r + CAP_W'(1);
            ok_nxt   = 1'b1;
          end
        end
        FUNC_INS_REAR: begin
          if (has_room) begin
            tail_nxt = tail_inc;
            wr_en    = 1'b1;
            wr_addr  = tail_inc;
            fill_nxt = fill_r + CAP_W'(1);
            ok_nxt   = 1'b1;
          end
        end
        FUNC_DEL_FRONT: begin
          if (has_data) begin
            head_nxt = head_inc;
            fill_nxt = fill_r - CAP_W'(1);
            ok_nxt   = 1'b1;
          end
        end
        FUNC_DEL_REAR: begin
          if (has_data) begin
            tail_nxt = tail_dec;
            fill_nxt = fill_r - CAP_W'(1);
            ok_nxt   = 1'b1;
          end
        end
        FUNC_PEEK: ok_nxt = 1'b1;
        default:   ok_nxt = 1'b0;
      endcase
    end
    // a capacity write empties the deque
    if (cfg_we) begin
      cap_nxt  = cap_eff;
      head_nxt = '0;
      tail_nxt = PTR_W'(cap_eff - CAP_W'(1));
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= PTR_W'(RST_CAP - 1);
      fill_r <= '0;
      cap_r  <= CAP_W'(RST_CAP);
      ok_r   <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
      cap_r  <= cap_nxt;
      ok_r   <= ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
  end

  // storage: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.read) begin
      rd_head_r <= mem[head_r];
      rd_tail_r <= mem[tail_r];
    end
  end

  assign out_valid_nxt = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.ok          <= ok_r;
      out_data_r.front_value <= has_data ? WORD_W'(rd_head_r) : '1;
      out_data_r.rear_value  <= has_data ? WORD_W'(rd_tail_r) : '1;
      out_data_r.is_empty    <= !has_data;
      out_data_r.is_full     <= (fill_r == cap_r);
      out_data_r.count       <= fill_r;
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

endmodule

// ===== sim/tb_circular_deque_top.sv =====
`timescale 1ns / 1ps
// Testbench for circular_deque_top: directed and random deque operations checked per word.
module tb_circular_deque_top;
  import cdq_pkg::*;

  localparam int SLOTS     = 16;
  localparam int RUN_LIMIT = 400000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  cdq_in_t              in_data;
  logic                 out_valid;
  logic                 out_ready;
  cdq_out_t             out_data;
  logic                 cfg_we;
  logic [CAP_W-1:0]     cfg_wdata;

  int idle_mode = 0;
  int cycles    = 0;

  // Behavioral deque plus the queue of result words it predicts.
  class deque_tracker;
    logic [WORD_W-1:0] slots [SLOTS];
    int                head;
    int                tail;
    int                fill;
    int                cap;
    cdq_out_t          expected_words [$];
    int                errors;

    function new();
      errors = 0;
      set_capacity(5'd16);
    endfunction

    // A capacity write also empties the deque.
    function void set_capacity(logic [CAP_W-1:0] v);
      if (v == 0) cap = 1;
      else if (v > SLOTS) cap = SLOTS;
      else cap = int'(v);
      head = 0;
      tail = cap - 1;
      fill = 0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void note_op(cdq_in_t w);
      cdq_out_t r;
      logic     ok;
      ok = 1'b0;
      case (w.func)
        FUNC_INS_FRONT: if (fill < cap) begin
          head = (head == 0) ? cap - 1 : head - 1;
          slots[head] = w.value;
          fill++;
          ok = 1'b1;
        end
        FUNC_INS_REAR: if (fill < cap) begin
          tail = (tail + 1 >= cap) ? 0 : tail + 1;
          slots[tail] = w.value;
          fill++;
          ok = 1'b1;
        end
        FUNC_DEL_FRONT: if (fill != 0) begin
          head = (head + 1 >= cap) ? 0 : head + 1;
          fill--;
          ok = 1'b1;
        end
        FUNC_DEL_REAR: if (fill != 0) begin
          tail = (tail == 0) ? cap - 1 : tail - 1;
          fill--;
          ok = 1'b1;
        end
        FUNC_PEEK: ok = 1'b1;
        default: ok = 1'b0;
      endcase
      r.ok          = ok;
      r.front_value = (fill == 0) ? '1 : slots[head];
      r.rear_value  = (fill == 0) ? '1 : slots[tail];
      r.is_empty    = (fill == 0);
      r.is_full     = (fill == cap);
      r.count       = fill[CAP_W-1:0];
      expected_words.push_back(r);
    endfunction

    function void check_word(cdq_out_t got);
      cdq_out_t exp;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: ok=%0b front=%0d rear=%0d empty=%0b full=%0b count=%0d",
                   got.ok, got.front_value, got.rear_value, got.is_empty, got.is_full,
                   got.count);
        return;
      end
      exp = expected_words.pop_front();
      if (got.ok !== exp.ok || got.front_value !== exp.front_value ||
          got.rear_value !== exp.rear_value || got.is_empty !== exp.is_empty ||
          got.is_full !== exp.is_full || got.count !== exp.count) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected ok=%0b front=%0d rear=%0d empty=%0b full=%0b count=%0d",
                   exp.ok, exp.front_value, exp.rear_value, exp.is_empty, exp.is_full,
                   exp.count);
          $display("          actual   ok=%0b front=%0d rear=%0d empty=%0b full=%0b count=%0d",
                   got.ok, got.front_value, got.rear_value, got.is_empty, got.is_full,
                   got.count);
        end
      end
    endfunction
  endclass

  deque_tracker tracker;

  circular_deque_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones; mode 0 means no idling at all.
  function automatic int gap_len();
    int r;
    if (idle_mode == 0) return 0;
    r = $urandom_range(99);
    if (r < ((idle_mode == 1) ? 75 : 45)) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [WORD_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Hold the word until accepted.
  task automatic send_word(input logic [2:0] f, input logic [WORD_W-1:0] v);
    cdq_in_t w;
    w.func  = f;
    w.value = v;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    tracker.note_op(w);
  endtask

  task automatic pause_sender();
    int n;
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Wait for every expected word, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_capacity(v);
  endtask

  // Runs of insert-heavy and delete-heavy traffic push the deque to full and empty.
  task automatic run_phase(input int n_ops, input bit hold_mid);
    int          fill_bias;
    int          run_left;
    int          r;
    logic [2:0]  f;
    fill_bias = 85;
    run_left  = 0;
    for (int k = 0; k < n_ops; k++) begin
      if (run_left == 0) begin
        fill_bias = $urandom_range(1) ? 85 : 15;
        run_left  = $urandom_range(4, 40);
      end
      run_left--;
      r = $urandom_range(99);
      if (r < 3) f = 3'($urandom_range(5, 7));
      else if (r < 7) f = FUNC_PEEK;
      else if ($urandom_range(99) < fill_bias)
        f = $urandom_range(1) ? FUNC_INS_FRONT : FUNC_INS_REAR;
      else
        f = $urandom_range(1) ? FUNC_DEL_FRONT : FUNC_DEL_REAR;
      send_word(f, pick_value());
      if (hold_mid && k == n_ops / 2) drain();
      else pause_sender();
    end
  endtask

  initial begin
    logic [CAP_W-1:0] caps [11];
    caps = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd8, 5'd0, 5'd17, 5'd5, 5'd2, 5'd12, 5'd16};
    tracker   = new();
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset capacity: empty deletes, extremes of the data word, undefined codes.
    idle_mode = 1;
    send_word(FUNC_PEEK, 32'h0);
    send_word(FUNC_DEL_FRONT, 32'h0);
    send_word(FUNC_DEL_REAR, 32'hFFFF_FFFF);
    send_word(FUNC_INS_FRONT, 32'h7FFF_FFFF);
    send_word(FUNC_INS_REAR, 32'h8000_0000);
    send_word(FUNC_INS_FRONT, 32'hFFFF_FFFF);
    send_word(FUNC_INS_REAR, 32'h0);
    send_word(FUNC_PEEK, 32'h1234_5678);
    send_word(3'd5, 32'h5555_5555);
    send_word(3'd6, 32'hAAAA_AAAA);
    send_word(3'd7, 32'h0F0F_0F0F);
    send_word(FUNC_DEL_FRONT, 32'h0);
    send_word(FUNC_DEL_REAR, 32'h0);
    send_word(FUNC_DEL_FRONT, 32'h0);
    send_word(FUNC_DEL_REAR, 32'h0);
    send_word(FUNC_DEL_REAR, 32'h0);

    // Single-entry deque: insert on full and delete on empty both fail.
    drain();
    write_capacity(5'd1);
    send_word(FUNC_INS_REAR, 32'h1234_5678);
    send_word(FUNC_INS_FRONT, 32'h1);
    send_word(FUNC_DEL_REAR, 32'h0);
    send_word(FUNC_DEL_FRONT, 32'h0);

    // Zero capacity acts as one.
    drain();
    write_capacity(5'd0);
    send_word(FUNC_INS_FRONT, 32'hA5A5_A5A5);
    send_word(FUNC_INS_REAR, 32'h5A5A_5A5A);

    // Wrap of the front pointer below zero.
    drain();
    write_capacity(5'd2);
    send_word(FUNC_INS_FRONT, 32'h0000_0011);
    send_word(FUNC_INS_FRONT, 32'h0000_0022);
    send_word(FUNC_INS_REAR, 32'h0000_0033);

    for (int i = 0; i < 11; i++) begin
      drain();
      write_capacity(caps[i]);
      idle_mode = i % 3;
      run_phase(140, (i % 4) == 1);
    end

    drain();
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Receiver: check each accepted word, then pick the next ready level.
  initial begin
    int stall;
    stall = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) tracker.check_word(out_data);
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        stall = gap_len();
        out_ready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

endmodule

// ===== sim.f =====
hdl/cdq_pkg.sv
hdl/cdq_ctrl.sv
hdl/cdq_dpath.sv
hdl/circular_deque_top.sv
sim/tb_circular_deque_top.sv
